>>> src/masked_bilateral_smoother_top_macros.svh
// Assertion macros for the masked bilateral smoother
`ifndef MASKED_BILATERAL_SMOOTHER_TOP_MACROS_SVH
`define MASKED_BILATERAL_SMOOTHER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst
`define MBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst
`define MBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mbs_pkg.sv
// Shared types, constants and the exponent fraction table of the smoother
package mbs_pkg;

  // item kinds
  localparam logic [1:0] KIND_WEIGHT  = 2'd0;
  localparam logic [1:0] KIND_PIXEL   = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_IMAGE_ROWS  = 3'd0;
  localparam logic [2:0] REG_IMAGE_COLS  = 3'd1;
  localparam logic [2:0] REG_KERNEL_ROWS = 3'd2;
  localparam logic [2:0] REG_KERNEL_COLS = 3'd3;
  localparam logic [2:0] REG_EDGE_COEF   = 3'd4;

  // fixed-point constants
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;

  // exponent fraction table, 2^(-f/256) in Q1.15
  localparam int EXP_ENTRIES = 256;
  localparam int EXP_IDX_W   = 8;

  // tap pipeline depth from issue to accumulator update
  localparam int DRAIN_CYCLES = 7;
  // quotient bits produced by the divider
  localparam int QUO_W = 24;

  typedef logic [15:0] exp_rom_t [EXP_ENTRIES];

  // series evaluation of exp(-y*ln2), done at elaboration
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t   rom;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] s;
    for (int f = 0; f < EXP_ENTRIES; f++) begin
      y    = (64'(f) << 32) / EXP_ENTRIES;
      z    = (y * 64'(LN2_Q32)) >> 32;
      sum  = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int k = 1; k <= 16; k++) begin
        term = ((term * z) >> 32) / 64'(k);
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      s = (sum + (64'd1 << 16)) >> 17;
      rom[f] = s[15:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  // configuration after clamping
  typedef struct packed {
    logic [12:0] rows;
    logic [12:0] cols;
    logic [4:0]  krows;
    logic [4:0]  kcols;
    logic [15:0] edge_coef;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       rd_centre;
    logic       latch_centre;
    logic       tap_issue;
    logic [4:0] tap_k;
    logic [4:0] tap_l;
    logic       div_prep;
    logic       div_check;
    logic       div_step;
    logic       load_out;
    logic       out_missing;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic centre_ok;
    logic wsum_zero;
  } stat_t;

endpackage

>>> src/mbs_if.sv
// Item and result channel interfaces
interface mbs_item_if;
  import mbs_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         row;
  logic [7:0]         col;
  logic signed [15:0] pixel_value;
  logic               pixel_missing;
  logic [15:0]        weight;

  modport source (output valid, kind, row, col, pixel_value, pixel_missing, weight,
                  input ready);
  modport sink (input valid, kind, row, col, pixel_value, pixel_missing, weight,
                output ready);
endinterface

interface mbs_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] smoothed_value;
  logic               result_missing;

  modport source (output valid, smoothed_value, result_missing, input ready);
  modport sink (input valid, smoothed_value, result_missing, output ready);
endinterface

>>> src/mbs_ctrl.sv
// Controller: sequences centre read, tap walk, drain, divide and output
module mbs_ctrl
  import mbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  cfg_t       cfg,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CENTRE = 9'b000000010,
    S_CWAIT  = 9'b000000100,
    S_WALK   = 9'b000001000,
    S_DRAIN  = 9'b000010000,
    S_PREP   = 9'b000100000,
    S_CHECK  = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] tk, tk_next;
  logic [4:0] tl, tl_next;
  logic [4:0] cnt, cnt_next;
  logic       miss, miss_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    tk_next    = tk;
    tl_next    = tl;
    cnt_next   = cnt;
    miss_next  = miss;
    cmd        = '0;
    cmd.tap_k  = tk;
    cmd.tap_l  = tl;
    cmd.out_missing = miss;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          miss_next  = 1'b0;
          if (in_kind == KIND_COMPUTE) begin
            state_next = S_CENTRE;
          end
        end
      end
      S_CENTRE: begin
        cmd.rd_centre = 1'b1;
        state_next    = S_CWAIT;
      end
      S_CWAIT: begin
        cmd.latch_centre = 1'b1;
        tk_next  = '0;
        tl_next  = '0;
        cnt_next = '0;
        if (!stat.centre_ok) begin
          miss_next  = 1'b1;
          state_next = S_FINISH;
        end else if (cfg.krows == '0 || cfg.kcols == '0) begin
          state_next = S_DRAIN;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.tap_issue = 1'b1;
        if (tl == cfg.kcols - 5'd1) begin
          tl_next = '0;
          if (tk == cfg.krows - 5'd1) begin
            state_next = S_DRAIN;
          end else begin
            tk_next = tk + 5'd1;
          end
        end else begin
          tl_next = tl + 5'd1;
        end
      end
      S_DRAIN: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(DRAIN_CYCLES - 1)) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.div_prep = 1'b1;
        if (stat.wsum_zero) begin
          miss_next  = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.div_check = 1'b1;
        cnt_next      = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 5'd1;
        if (cnt == 5'(QUO_W - 1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tk        <= '0;
      tl        <= '0;
      cnt       <= '0;
      miss      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      tk    <= tk_next;
      tl    <= tl_next;
      cnt   <= cnt_next;
      miss  <= miss_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/mbs_datapath.sv
// Datapath: image and weight memories, tap pipeline, accumulators, divider
module mbs_datapath
  import mbs_pkg::*;
#(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_KERNEL = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_row,
  input  logic [7:0]         in_col,
  input  logic signed [15:0] in_pixel_value,
  input  logic               in_pixel_missing,
  input  logic [15:0]        in_weight,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic signed [23:0] smoothed_value,
  output logic               result_missing
);

  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int WT_DEPTH  = MAX_KERNEL * MAX_KERNEL;
  localparam int WT_AW     = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
  localparam int TAP_W     = $clog2(WT_DEPTH + 1);
  localparam int WSUM_W    = 31 + TAP_W;
  localparam int VSUM_W    = 47 + TAP_W;
  localparam int DIV_W     = VSUM_W + 8;

  // memories
  logic [16:0] image_mem [IMG_DEPTH];
  logic [15:0] weight_mem [WT_DEPTH];

  logic [7:0]  row_q, col_q;
  logic [16:0] image_q;
  logic [15:0] weight_q;
  logic        in_rng_q;
  logic signed [15:0] centre_q;

  // write decode
  logic [31:0] img_waddr_full, wt_waddr_full;
  logic        img_we, wt_we;
  assign img_waddr_full = 32'(in_row) * 32'(MAX_COLS) + 32'(in_col);
  assign wt_waddr_full  = 32'(in_row) * 32'(MAX_KERNEL) + 32'(in_col);
  assign img_we = cmd.accept && in_kind == KIND_PIXEL &&
                  13'(in_row) < 13'(MAX_ROWS) && 13'(in_col) < 13'(MAX_COLS);
  assign wt_we  = cmd.accept && in_kind == KIND_WEIGHT &&
                  9'(in_row) < 9'(MAX_KERNEL) && 9'(in_col) < 9'(MAX_KERNEL);

  // tap coordinates of the window, centred at kernel size / 2
  logic signed [13:0] di, dj;
  logic               in_img;
  logic [31:0]        tap_addr_full, centre_addr_full, wt_raddr_full;
  logic [IMG_AW-1:0]  img_raddr;
  logic               centre_rng;

  assign di = $signed({6'b0, row_q}) + $signed({9'b0, cmd.tap_k})
            - $signed({10'b0, cfg.krows[4:1]});
  assign dj = $signed({6'b0, col_q}) + $signed({9'b0, cmd.tap_l})
            - $signed({10'b0, cfg.kcols[4:1]});
  assign in_img = di >= 14'sd0 && dj >= 14'sd0 &&
                  di < $signed({1'b0, cfg.rows}) && dj < $signed({1'b0, cfg.cols});
  assign tap_addr_full    = 32'(di[12:0]) * 32'(MAX_COLS) + 32'(dj[12:0]);
  assign centre_addr_full = 32'(row_q) * 32'(MAX_COLS) + 32'(col_q);
  assign wt_raddr_full    = 32'(cmd.tap_k) * 32'(MAX_KERNEL) + 32'(cmd.tap_l);
  assign img_raddr  = cmd.rd_centre ? IMG_AW'(centre_addr_full) : IMG_AW'(tap_addr_full);
  assign centre_rng = 13'(row_q) < cfg.rows && 13'(col_q) < cfg.cols;

  // image memory port
  always_ff @(posedge clk) begin
    if (img_we) begin
      image_mem[IMG_AW'(img_waddr_full)] <= {in_pixel_missing, in_pixel_value};
    end
    image_q <= image_mem[img_raddr];
  end

  // weight memory port
  always_ff @(posedge clk) begin
    if (wt_we) begin
      weight_mem[WT_AW'(wt_waddr_full)] <= in_weight;
    end
    weight_q <= weight_mem[WT_AW'(wt_raddr_full)];
  end

  // item coordinates and centre sample
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_q <= in_row;
      col_q <= in_col;
    end
    if (cmd.rd_centre) begin
      in_rng_q <= centre_rng;
    end
    if (cmd.latch_centre) begin
      centre_q <= image_q[15:0];
    end
  end
  assign stat.centre_ok = in_rng_q && !image_q[16];

  // tap pipeline valids
  logic v1, v2, v3, v4, v5, v6;
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
    end else begin
      v1 <= cmd.tap_issue && in_img;
      v2 <= v1 && !image_q[16];
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // stage 1: absolute difference times edge coefficient
  logic signed [16:0] diff;
  logic [15:0]        absdiff;
  logic [31:0]        x2;
  logic signed [15:0] nv2, nv3, nv4, nv5;
  logic [15:0]        wt2, wt3, wt4;
  assign diff    = 17'(centre_q) - 17'(signed'(image_q[15:0]));
  assign absdiff = diff[16] ? 16'(-diff) : diff[15:0];
  always_ff @(posedge clk) begin
    x2  <= 32'(absdiff) * 32'(cfg.edge_coef);
    nv2 <= image_q[15:0];
    wt2 <= weight_q;
  end

  // stage 2: log2(e) scaling, Q16 exponent
  logic [49:0] tprod;
  logic [41:0] t3;
  assign tprod = 50'(x2) * 50'(LOG2E_Q16) + 50'd128;
  always_ff @(posedge clk) begin
    t3  <= tprod[49:8];
    nv3 <= nv2;
    wt3 <= wt2;
  end

  // stage 3: table lookup and integer shift
  logic [15:0] sm4;
  logic [15:0] rom_q;
  assign rom_q = EXP_ROM[t3[15 -: EXP_IDX_W]];
  always_ff @(posedge clk) begin
    sm4 <= (|t3[41:20]) ? 16'd0 : (rom_q >> t3[19:16]);
    nv4 <= nv3;
    wt4 <= wt3;
  end

  // stage 4: tap weight
  logic [31:0] w5;
  always_ff @(posedge clk) begin
    w5  <= 32'(wt4) * 32'(sm4);
    nv5 <= nv4;
  end

  // stage 5: weighted sample
  logic signed [48:0] p6;
  logic [31:0]        w6;
  always_ff @(posedge clk) begin
    p6 <= $signed({1'b0, w5}) * nv5;
    w6 <= w5;
  end

  // stage 6: accumulators
  logic signed [VSUM_W-1:0] vsum;
  logic [WSUM_W-1:0]        wsum;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      vsum <= '0;
      wsum <= '0;
    end else if (v6) begin
      vsum <= vsum + VSUM_W'(p6);
      wsum <= wsum + WSUM_W'(w6);
    end
  end
  assign stat.wsum_zero = (wsum == '0);

  // divider: dividend, overflow check, one quotient bit per cycle
  logic signed [DIV_W-1:0] num;
  logic [DIV_W-1:0]        mag;
  logic [DIV_W-1:0]        dividend;
  logic                    neg, sat;
  logic [WSUM_W-1:0]       rem;
  logic [WSUM_W:0]         rem2;
  logic [QUO_W-1:0]        dlow, quo;
  logic [DIV_W+WSUM_W-1:0] dividend_x, wsum_x;

  assign num  = DIV_W'(vsum) <<< 8;
  assign mag  = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
  assign dividend_x = (DIV_W+WSUM_W)'(dividend);
  assign wsum_x     = (DIV_W+WSUM_W)'(wsum) << QUO_W;
  assign rem2 = {rem, dlow[QUO_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_prep) begin
      dividend <= mag + DIV_W'(wsum >> 1);
      neg      <= vsum[VSUM_W-1];
    end
    if (cmd.div_check) begin
      sat  <= dividend_x >= wsum_x;
      rem  <= WSUM_W'(dividend >> QUO_W);
      dlow <= dividend[QUO_W-1:0];
      quo  <= '0;
    end
    if (cmd.div_step) begin
      if (rem2 >= (WSUM_W+1)'(wsum)) begin
        rem <= WSUM_W'(rem2 - (WSUM_W+1)'(wsum));
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= rem2[WSUM_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      dlow <= dlow << 1;
    end
  end

  // output register with rounding saturation
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_missing <= cmd.out_missing;
      if (cmd.out_missing) begin
        smoothed_value <= '0;
      end else if (neg) begin
        if (sat || quo > 24'd8388608) begin
          smoothed_value <= -24'sd8388608;
        end else begin
          smoothed_value <= -$signed(quo);
        end
      end else begin
        if (sat || quo > 24'd8388607) begin
          smoothed_value <= 24'sd8388607;
        end else begin
          smoothed_value <= $signed(quo);
        end
      end
    end
  end

endmodule

>>> src/masked_bilateral_smoother_top.sv
// Top level of the masked bilateral smoother: registers, controller, datapath
//
//  channel  direction  transfer
//  item     in         kind, row, col, pixel_value, pixel_missing, weight
//  result   out        smoothed_value, result_missing (one per compute item)
//  apb      in         register writes and reads, pready always high
//
// A compute item runs a centre read, one tap per cycle through the single
// image memory port, a pipeline drain and a restoring divider. Synchronous
// reset clears control state only; memories start undefined. A result
// waiting in the output register does not block writes; a following
// compute item holds in its last step.
`include "masked_bilateral_smoother_top_macros.svh"
module masked_bilateral_smoother_top
  import mbs_pkg::*;
#(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_KERNEL = 9
) (
  input  logic        clk,
  input  logic        rst,
  mbs_item_if.sink    item,
  mbs_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0]  image_rows, image_cols;
  logic [3:0]  kernel_rows, kernel_cols;
  logic [15:0] edge_coef;
  logic [2:0]  reg_idx;
  cfg_t        cfg;
  cmd_t        cmd;
  stat_t       stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= 9'd256;
      image_cols  <= 9'd256;
      kernel_rows <= 4'd3;
      kernel_cols <= 4'd3;
      edge_coef   <= 16'd256;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_IMAGE_ROWS:  image_rows  <= pwdata[8:0];
        REG_IMAGE_COLS:  image_cols  <= pwdata[8:0];
        REG_KERNEL_ROWS: kernel_rows <= pwdata[3:0];
        REG_KERNEL_COLS: kernel_cols <= pwdata[3:0];
        REG_EDGE_COEF:   edge_coef   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_ROWS:  prdata = 32'(image_rows);
      REG_IMAGE_COLS:  prdata = 32'(image_cols);
      REG_KERNEL_ROWS: prdata = 32'(kernel_rows);
      REG_KERNEL_COLS: prdata = 32'(kernel_cols);
      REG_EDGE_COEF:   prdata = 32'(edge_coef);
      default:         prdata = '0;
    endcase
  end

  // sizes clamped to the store dimensions
  assign cfg.rows  = (13'(image_rows) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(image_rows);
  assign cfg.cols  = (13'(image_cols) > 13'(MAX_COLS)) ? 13'(MAX_COLS) : 13'(image_cols);
  assign cfg.krows = (5'(kernel_rows) > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : 5'(kernel_rows);
  assign cfg.kcols = (5'(kernel_cols) > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : 5'(kernel_cols);
  assign cfg.edge_coef = edge_coef;

  mbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_kind   (item.kind),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cfg       (cfg),
    .stat      (stat),
    .cmd       (cmd)
  );

  mbs_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .in_kind          (item.kind),
    .in_row           (item.row),
    .in_col           (item.col),
    .in_pixel_value   (item.pixel_value),
    .in_pixel_missing (item.pixel_missing),
    .in_weight        (item.weight),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .smoothed_value   (result.smoothed_value),
    .result_missing   (result.result_missing)
  );

  // checks
  `MBS_ASSERT_IMP(a_missing_zero, result.valid && result.result_missing, result.smoothed_value == 24'sd0, "missing result carries a value")
  `MBS_ASSERT_NXT(a_busy_after_compute, item.valid && item.ready && item.kind == KIND_COMPUTE, !item.ready, "compute transfer did not make the block busy")
  `MBS_ASSERT_IMP(a_result_after_work, $rose(result.valid), $past(!item.ready), "result appeared without work")

endmodule

>>> sim/masked_bilateral_smoother_top_tb.sv
// Self-checking testbench for the masked bilateral smoother top level
module masked_bilateral_smoother_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbs_pkg::*;

  localparam int IMG_W = 256;
  localparam int KMAX = 9;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic signed [23:0] value;
    logic               missing;
  } smoothed_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mbs_item_if   item_ch ();
  mbs_result_if res_ch ();

  masked_bilateral_smoother_top uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow state of the block
  logic [15:0] img_val [IMG_W*IMG_W];
  bit          img_miss [IMG_W*IMG_W];
  bit          img_loaded [IMG_W*IMG_W];
  logic [15:0] kern_wt [KMAX*KMAX];
  logic [15:0] frac_rom [256];
  int unsigned reg_rows, reg_cols, reg_krows, reg_kcols, reg_coef;

  smoothed_t pending_smoothed[$];
  int  mismatches;
  int  computes_sent;
  int  results_seen;
  int  phases_run;
  bit  quiet;
  bit  item_xfer;
  bit  res_xfer;
  int  stall_left;
  int  idle_count;
  logic [15:0] base_level;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // 2^(-f/256) in Q1.15 by an alternating series of exp(-f*ln2/256)
  function automatic void fill_frac_rom();
    longint unsigned y, z, acc, term;
    for (int f = 0; f < 256; f++) begin
      y = (longint'(f) << 32) / 256;
      z = (y * 64'd2977044472) >> 32;
      acc = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int k = 1; k <= 16; k++) begin
        term = ((term * z) >> 32) / longint'(k);
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      frac_rom[f] = 16'((acc + (64'd1 << 16)) >> 17);
    end
  endfunction

  // range falloff for one absolute difference
  function automatic longint unsigned range_factor(longint unsigned absdiff);
    longint unsigned x, t, n, idx;
    x = absdiff * reg_coef;
    t = (x * 64'd94548 + 64'd128) >> 8;
    n = t >> 16;
    idx = ((t & 64'hFFFF) * 256) >> 16;
    if (n >= 16) return 0;
    return longint'(frac_rom[idx]) >> n;
  endfunction

  function automatic int clamp_to(int unsigned v, int unsigned hi);
    return (v > hi) ? hi : v;
  endfunction

  // weighted average around one centre pixel
  function automatic smoothed_t smooth_pixel(int r, int c);
    smoothed_t res;
    int rows, cols, kr, kc, di, dj, ctr, nv, ad;
    longint vsum, num;
    longint unsigned wsum, w, mag, q;
    rows = clamp_to(reg_rows, IMG_W);
    cols = clamp_to(reg_cols, IMG_W);
    kr = clamp_to(reg_krows, KMAX);
    kc = clamp_to(reg_kcols, KMAX);
    vsum = 0;
    wsum = 0;
    res.value = '0;
    res.missing = 1'b1;
    if (r >= rows || c >= cols) return res;
    if (img_miss[r*IMG_W+c]) return res;
    ctr = $signed(img_val[r*IMG_W+c]);
    for (int k = 0; k < kr; k++) begin
      for (int l = 0; l < kc; l++) begin
        di = r + k - kr/2;
        dj = c + l - kc/2;
        if (di < 0 || dj < 0 || di >= rows || dj >= cols) continue;
        if (img_miss[di*IMG_W+dj]) continue;
        nv = $signed(img_val[di*IMG_W+dj]);
        ad = (ctr > nv) ? ctr - nv : nv - ctr;
        w = longint'(kern_wt[k*KMAX+l]) * range_factor(ad);
        vsum += longint'(w) * nv;
        wsum += w;
      end
    end
    if (wsum == 0) return res;
    num = vsum * 256;
    mag = (num < 0) ? -num : num;
    q = (mag + wsum/2) / wsum;
    if (num < 0) begin
      if (q > 8388608) q = 8388608;
      res.value = 24'(-longint'(q));
    end else begin
      if (q > 8388607) q = 8388607;
      res.value = 24'(q);
    end
    res.missing = 1'b0;
    return res;
  endfunction

  // true when the centre lies outside the image, or when the centre and every in-image tap have been written
  function automatic bit window_loaded(int r, int c);
    int rows, cols, kr, kc, di, dj;
    rows = clamp_to(reg_rows, IMG_W);
    cols = clamp_to(reg_cols, IMG_W);
    kr = clamp_to(reg_krows, KMAX);
    kc = clamp_to(reg_kcols, KMAX);
    if (r >= rows || c >= cols) return 1;
    if (!img_loaded[r*IMG_W+c]) return 0;
    for (int k = 0; k < kr; k++) begin
      for (int l = 0; l < kc; l++) begin
        di = r + k - kr/2;
        dj = c + l - kc/2;
        if (di < 0 || dj < 0 || di >= rows || dj >= cols) continue;
        if (!img_loaded[di*IMG_W+dj]) return 0;
      end
    end
    return 1;
  endfunction

  // one item transfer; shadow state and expectations update on acceptance
  task automatic send_item(logic [1:0] kind, logic [7:0] r, logic [7:0] c,
                           logic [15:0] val, logic miss, logic [15:0] wt);
    bit rdy;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.kind          <= kind;
    item_ch.row           <= r;
    item_ch.col           <= c;
    item_ch.pixel_value   <= val;
    item_ch.pixel_missing <= miss;
    item_ch.weight        <= wt;
    forever begin
      @(negedge clk);
      rdy = item_ch.ready;
      @(posedge clk);
      if (rdy) break;
    end
    case (kind)
      KIND_WEIGHT: begin
        if (r < KMAX && c < KMAX) kern_wt[r*KMAX+c] = wt;
      end
      KIND_PIXEL: begin
        img_val[r*IMG_W+c] = val;
        img_miss[r*IMG_W+c] = miss;
        img_loaded[r*IMG_W+c] = 1'b1;
      end
      KIND_COMPUTE: begin
        pending_smoothed.push_back(smooth_pixel(r, c));
        computes_sent++;
      end
      default: ;
    endcase
  endtask

  // APB register write, setup then access
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_IMAGE_ROWS:  reg_rows  = data & 32'h1FF;
      REG_IMAGE_COLS:  reg_cols  = data & 32'h1FF;
      REG_KERNEL_ROWS: reg_krows = data & 32'hF;
      REG_KERNEL_COLS: reg_kcols = data & 32'hF;
      REG_EDGE_COEF:   reg_coef  = data & 32'hFFFF;
      default: ;
    endcase
  endtask

  // wait until every expected result is back and the block has settled
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_smoothed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int unsigned rows, int unsigned cols, int unsigned kr,
                           int unsigned kc, int unsigned coef);
    drain();
    write_reg(REG_IMAGE_ROWS, rows);
    write_reg(REG_IMAGE_COLS, cols);
    write_reg(REG_KERNEL_ROWS, kr);
    write_reg(REG_KERNEL_COLS, kc);
    write_reg(REG_EDGE_COEF, coef);
    phases_run++;
  endtask

  // mostly a smooth surface, sometimes a full-range sample
  function automatic logic [15:0] pick_sample();
    if ($urandom_range(0, 9) < 7) return base_level + 16'($urandom_range(0, 40)) - 16'd20;
    return 16'($urandom);
  endfunction

  // coordinate in one of the two loaded corner regions
  task automatic pick_spot(output logic [7:0] r, output logic [7:0] c);
    if ($urandom_range(0, 2) != 0) begin
      r = 8'($urandom_range(0, 15));
      c = 8'($urandom_range(0, 15));
    end else begin
      r = 8'($urandom_range(248, 255));
      c = 8'($urandom_range(248, 255));
    end
  endtask

  task automatic send_compute_safe();
    logic [7:0] r, c;
    do pick_spot(r, c); while (!window_loaded(r, c));
    send_item(KIND_COMPUTE, r, c, 16'($urandom), 1'($urandom), 16'($urandom));
  endtask

  // load all kernel weights and both corner regions of the image
  task automatic test_preload();
    for (int k = 0; k < KMAX; k++) begin
      for (int l = 0; l < KMAX; l++) begin
        send_item(KIND_WEIGHT, 8'(k), 8'(l), 16'($urandom), 1'($urandom), 16'($urandom));
      end
    end
    for (int r = 0; r < 16; r++) begin
      for (int c = 0; c < 16; c++) begin
        send_item(KIND_PIXEL, 8'(r), 8'(c), pick_sample(),
                  $urandom_range(0, 9) == 0, 16'($urandom));
      end
    end
    for (int r = 248; r < 256; r++) begin
      for (int c = 248; c < 256; c++) begin
        send_item(KIND_PIXEL, 8'(r), 8'(c), pick_sample(),
                  $urandom_range(0, 9) == 0, 16'($urandom));
      end
    end
  endtask

  // edges, missing centre, outside centre, extremes, zero weights, ignored items
  task automatic test_directed();
    configure(16, 16, 3, 3, 256);
    send_item(KIND_PIXEL, 8'd5, 8'd5, 16'h7FFF, 1'b0, 16'h0000);
    send_item(KIND_PIXEL, 8'd5, 8'd6, 16'h8000, 1'b0, 16'hFFFF);
    send_item(KIND_PIXEL, 8'd5, 8'd4, 16'h7FFF, 1'b0, 16'h0000);
    send_item(KIND_PIXEL, 8'd9, 8'd9, 16'h1234, 1'b1, 16'h0000);
    send_item(KIND_WEIGHT, 8'd1, 8'd1, 16'hFFFF, 1'b0, 16'hFFFF);
    send_item(KIND_COMPUTE, 8'd5, 8'd5, 16'h0, 1'b0, 16'h0);
    send_item(KIND_COMPUTE, 8'd5, 8'd6, 16'h0, 1'b0, 16'h0);
    send_item(KIND_COMPUTE, 8'd9, 8'd9, 16'h0, 1'b0, 16'h0);
    send_item(KIND_COMPUTE, 8'd0, 8'd0, 16'h0, 1'b0, 16'h0);
    send_item(KIND_COMPUTE, 8'd15, 8'd15, 16'h0, 1'b0, 16'h0);
    send_item(KIND_COMPUTE, 8'd16, 8'd3, 16'h0, 1'b0, 16'h0);
    send_item(KIND_COMPUTE, 8'd255, 8'd255, 16'h0, 1'b0, 16'h0);
    // weight writes beyond the kernel store and the unused kind are dropped
    send_item(KIND_WEIGHT, 8'd9, 8'd0, 16'h0, 1'b0, 16'h0000);
    send_item(KIND_WEIGHT, 8'd255, 8'd255, 16'h0, 1'b0, 16'h0000);
    send_item(2'd3, 8'd5, 8'd5, 16'h0, 1'b0, 16'h0);
    send_item(KIND_COMPUTE, 8'd5, 8'd5, 16'h0, 1'b0, 16'h0);
    // zero kernel gives an empty weight sum
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        send_item(KIND_WEIGHT, 8'(k), 8'(l), 16'h0, 1'b0, 16'h0000);
      end
    end
    send_item(KIND_COMPUTE, 8'd7, 8'd7, 16'h0, 1'b0, 16'h0);
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        send_item(KIND_WEIGHT, 8'(k), 8'(l), 16'h0, 1'b0, 16'($urandom));
      end
    end
  endtask

  // random mix of computes, rewrites and ignored items under one setting
  task automatic test_random_phase(int unsigned rows, int unsigned cols, int unsigned kr,
                                   int unsigned kc, int unsigned coef, int count);
    logic [7:0] r, c;
    int sel;
    configure(rows, cols, kr, kc, coef);
    base_level = 16'($urandom);
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        send_compute_safe();
      end else if (sel < 85) begin
        pick_spot(r, c);
        send_item(KIND_PIXEL, r, c, pick_sample(), $urandom_range(0, 9) == 0,
                  16'($urandom));
      end else if (sel < 96) begin
        send_item(KIND_WEIGHT, 8'($urandom_range(0, 11)), 8'($urandom_range(0, 11)),
                  16'($urandom), 1'($urandom), 16'($urandom));
      end else begin
        send_item(2'd3, 8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom),
                  16'($urandom));
      end
    end
  endtask

  // result ready with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // sample handshakes mid-cycle; the transfer happens at the next rising edge
  always @(negedge clk) begin
    item_xfer = !rst && item_ch.valid && item_ch.ready;
    res_xfer = !rst && res_ch.valid && res_ch.ready;
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    smoothed_t exp_r;
    if (res_xfer) begin
      results_seen++;
      if (pending_smoothed.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result value=%0d missing=%0b", $time,
                 res_ch.smoothed_value, res_ch.result_missing);
      end else begin
        exp_r = pending_smoothed.pop_front();
        if (res_ch.smoothed_value !== exp_r.value) begin
          mismatches++;
          $display("%0t: smoothed_value expected %0d actual %0d", $time,
                   exp_r.value, res_ch.smoothed_value);
        end
        if (res_ch.result_missing !== exp_r.missing) begin
          mismatches++;
          $display("%0t: result_missing expected %0b actual %0b", $time,
                   exp_r.missing, res_ch.result_missing);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || item_xfer || res_xfer || psel) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    item_ch.valid <= 1'b0;
    item_ch.kind <= KIND_WEIGHT;
    item_ch.row <= '0;
    item_ch.col <= '0;
    item_ch.pixel_value <= '0;
    item_ch.pixel_missing <= 1'b0;
    item_ch.weight <= '0;
    idle_count <= 0;
    item_xfer = 0;
    res_xfer = 0;
    quiet = 0;
    mismatches = 0;
    computes_sent = 0;
    results_seen = 0;
    phases_run = 0;
    base_level = 16'd1000;
    reg_rows = 256;
    reg_cols = 256;
    reg_krows = 3;
    reg_kcols = 3;
    reg_coef = 256;
    fill_frac_rom();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_preload();
    test_directed();
    test_random_phase(256, 256, 9, 9, 0, 120);
    test_random_phase(511, 300, 15, 1, 65535, 100);
    test_random_phase(5, 9, 1, 9, 1, 100);
    test_random_phase(0, 16, 3, 3, 256, 40);
    test_random_phase(16, 1, 5, 7, $urandom_range(1, 2000), 120);
    test_random_phase(256, 256, 4, 2, $urandom_range(0, 65535), 100);
    test_random_phase(256, 256, 0, 3, 128, 40);
    test_random_phase(12, 14, 3, 5, 20, 120);
    test_random_phase(256, 256, 3, 3, 256, 60);
    quiet = 1;
    test_random_phase(256, 256, 7, 9, 8, 115);
    drain();

    $display("Covered %0d register settings, %0d compute items, %0d results checked.",
             phases_run, computes_sent, results_seen);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/mbs_pkg.sv
src/mbs_if.sv
src/mbs_ctrl.sv
src/mbs_datapath.sv
src/masked_bilateral_smoother_top.sv
sim/masked_bilateral_smoother_top_tb.sv
